/* rtl/fpad_pkg.sv */
package fpad_pkg;

	localparam int WORD_W     = 32;
	localparam int DIV_STAGES = WORD_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 29;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGES_PER_BLOCK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_CHIP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHIP_COUNT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANES_PER_CHIP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGES_PER_CHIP  = 3'd5;

	typedef enum logic [2:0] {
		SCOPE_PAGE    = 3'd0,
		SCOPE_BLOCK   = 3'd1,
		SCOPE_PLANE   = 3'd2,
		SCOPE_CHIP    = 3'd3,
		SCOPE_CHANNEL = 3'd4,
		SCOPE_SSD     = 3'd5
	} scope_t;

	typedef struct packed {
		logic [31:0] page_number;
		logic [31:0] scope_address;
		logic [2:0]  scope;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  chip_index;
		logic [15:0] block_index;
		logic [11:0] page_index;
		logic [11:0] plane_index;
		logic [5:0]  channel_index;
		logic        chip_out_of_range;
		logic [31:0] scope_first_page;
		logic        scope_invalid;
	} result_t;

endpackage

/* rtl/fpad_div.sv */
module fpad_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [fpad_pkg::WORD_W-1:0] dividend,
	input  logic [fpad_pkg::WORD_W-1:0] divisor,
	output logic                       out_valid,
	output logic [fpad_pkg::WORD_W-1:0] quotient,
	output logic [fpad_pkg::WORD_W-1:0] remainder
);
	import fpad_pkg::*;

	// one quotient bit per stage; the user must hold the divisor steady, the block does not enforce it
	logic              v_s   [DIV_STAGES];
	logic [WORD_W-1:0] rem_s [DIV_STAGES];
	logic [WORD_W-1:0] num_s [DIV_STAGES];
	logic [WORD_W-1:0] quo_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic              v_in;
		logic [WORD_W-1:0] rem_in;
		logic [WORD_W-1:0] num_in;
		logic [WORD_W-1:0] quo_in;
		logic [WORD_W:0]   trial;
		logic              take;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = '0;
			assign num_in = dividend;
			assign quo_in = '0;
		end else begin : g_next
			assign v_in   = v_s[k-1];
			assign rem_in = rem_s[k-1];
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = {rem_in, num_in[WORD_W-1]};
		assign take  = trial >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= take ? WORD_W'(trial - {1'b0, divisor}) : trial[WORD_W-1:0];
			num_s[k] <= {num_in[WORD_W-2:0], 1'b0};
			quo_s[k] <= {quo_in[WORD_W-2:0], take};
		end
	end

	assign out_valid = v_s[DIV_STAGES-1];
	assign quotient  = quo_s[DIV_STAGES-1];
	assign remainder = rem_s[DIV_STAGES-1];

endmodule

/* rtl/flash_page_address_decoder.sv */
// result_valid follows start through three chained 32-stage restoring
// dividers (page, block/chip, plane/channel) and an output register
// throughput: one word per cycle; busy is always low
// results are strobed for one cycle and cannot be held off
// reset: arst_n clears all valid bits and loads the register defaults
module flash_page_address_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  fpad_pkg::cmd_t                    cmd,
	output logic                              result_valid,
	output fpad_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [fpad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fpad_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fpad_pkg::*;

	localparam int L = DIV_STAGES;

	logic [12:0] ppb_q;
	logic [16:0] bpc_q;
	logic [8:0]  chip_count_q;
	logic [4:0]  planes_q;
	logic [6:0]  chans_q;
	logic [28:0] ppc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppb_q        <= 13'd128;
			bpc_q        <= 17'd1024;
			chip_count_q <= 9'd8;
			planes_q     <= 5'd1;
			chans_q      <= 7'd4;
			ppc_q        <= 29'd131072;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAGES_PER_BLOCK: ppb_q        <= cfg_data[12:0];
				CFG_BLOCKS_PER_CHIP: bpc_q        <= cfg_data[16:0];
				CFG_CHIP_COUNT:      chip_count_q <= cfg_data[8:0];
				CFG_PLANES_PER_CHIP: planes_q     <= cfg_data[4:0];
				CFG_CHANNEL_COUNT:   chans_q      <= cfg_data[6:0];
				CFG_PAGES_PER_CHIP:  ppc_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero divisors act as one
	logic [12:0] ppb_nz;
	logic [16:0] bpc_nz;
	logic [4:0]  planes_nz;
	logic [6:0]  chans_nz;
	assign ppb_nz    = (ppb_q == '0) ? 13'd1 : ppb_q;
	assign bpc_nz    = (bpc_q == '0) ? 17'd1 : bpc_q;
	assign planes_nz = (planes_q == '0) ? 5'd1 : planes_q;
	assign chans_nz  = (chans_q == '0) ? 7'd1 : chans_q;

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// page number split
	logic              a_valid, b_valid, c_valid, d_valid, p_valid;
	logic [WORD_W-1:0] a_quo, a_rem, b_quo, b_rem, c_quo, c_rem, d_quo, d_rem;
	logic [WORD_W-1:0] p_quo, p_rem;

	fpad_div u_div_page (
		.clk, .arst_n,
		.in_valid (accept),
		.dividend (cmd.page_number),
		.divisor  (WORD_W'(ppb_nz)),
		.out_valid(a_valid),
		.quotient (a_quo),
		.remainder(a_rem)
	);

	fpad_div u_div_block (
		.clk, .arst_n,
		.in_valid (a_valid),
		.dividend (a_quo),
		.divisor  (WORD_W'(bpc_nz)),
		.out_valid(b_valid),
		.quotient (b_quo),
		.remainder(b_rem)
	);

	fpad_div u_div_chan (
		.clk, .arst_n,
		.in_valid (b_valid),
		.dividend (b_quo),
		.divisor  (WORD_W'(chans_nz)),
		.out_valid(c_valid),
		.quotient (c_quo),
		.remainder(c_rem)
	);

	fpad_div u_div_plane (
		.clk, .arst_n,
		.in_valid (b_valid),
		.dividend (b_rem),
		.divisor  (WORD_W'(planes_nz)),
		.out_valid(d_valid),
		.quotient (d_quo),
		.remainder(d_rem)
	);

	// scope address split for the plane scope
	fpad_div u_div_scope (
		.clk, .arst_n,
		.in_valid (accept),
		.dividend (cmd.scope_address),
		.divisor  (WORD_W'(planes_nz)),
		.out_valid(p_valid),
		.quotient (p_quo),
		.remainder(p_rem)
	);

	// alignment lines
	logic [WORD_W-1:0] addr_d   [L];
	logic [2:0]        scope_d  [L];
	logic [WORD_W-1:0] page_d   [2*L];
	logic [WORD_W-1:0] chip_d   [L];
	logic [WORD_W-1:0] fp_d     [2*L-2];
	logic              inval_d  [2*L-2];

	logic [WORD_W-1:0] fp_s2;
	logic              inval_s2;

	always_ff @(posedge clk) begin
		addr_d[0]  <= cmd.scope_address;
		scope_d[0] <= cmd.scope;
		page_d[0]  <= a_rem;
		chip_d[0]  <= b_quo;
		fp_d[0]    <= fp_s2;
		inval_d[0] <= inval_s2;
		for (int i = 1; i < L; i++) begin
			addr_d[i]  <= addr_d[i-1];
			scope_d[i] <= scope_d[i-1];
			chip_d[i]  <= chip_d[i-1];
		end
		for (int i = 1; i < 2*L; i++) begin
			page_d[i] <= page_d[i-1];
		end
		for (int i = 1; i < 2*L-2; i++) begin
			fp_d[i]    <= fp_d[i-1];
			inval_d[i] <= inval_d[i-1];
		end
	end

	// first page: products, then select and add
	logic [WORD_W-1:0] mq_s1, mr_s1, mb_s1, mc_s1, addr_s1;
	logic [2:0]        scope_s1;

	always_ff @(posedge clk) begin
		mq_s1    <= WORD_W'(p_quo * WORD_W'(ppc_q));
		mr_s1    <= WORD_W'(p_rem[4:0]) * WORD_W'(ppb_q);
		mb_s1    <= WORD_W'(addr_d[L-1] * WORD_W'(ppb_q));
		mc_s1    <= WORD_W'(addr_d[L-1] * WORD_W'(ppc_q));
		addr_s1  <= addr_d[L-1];
		scope_s1 <= scope_d[L-1];
	end

	logic [WORD_W-1:0] fp_next;
	logic              inval_next;

	always_comb begin
		inval_next = 1'b0;
		unique case (scope_s1)
			SCOPE_PAGE:    fp_next = addr_s1;
			SCOPE_BLOCK:   fp_next = mb_s1;
			SCOPE_PLANE:   fp_next = (planes_nz > 5'd1) ? mq_s1 + mr_s1 : mc_s1;
			SCOPE_CHIP:    fp_next = mc_s1;
			SCOPE_CHANNEL: fp_next = mc_s1;
			SCOPE_SSD:     fp_next = '0;
			default: begin
				fp_next    = '1;
				inval_next = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		fp_s2    <= fp_next;
		inval_s2 <= inval_next;
	end

	// block index rides its own line, level with the chip
	logic [15:0] block_d [L];
	always_ff @(posedge clk) begin
		block_d[0] <= b_rem[15:0];
		for (int i = 1; i < L; i++) begin
			block_d[i] <= block_d[i-1];
		end
	end

	// output stage
	logic [WORD_W-1:0] chip_full;
	logic              oor;
	result_t           res_next;

	assign chip_full = chip_d[L-1];
	assign oor       = chip_full >= WORD_W'(chip_count_q);

	always_comb begin
		res_next.chip_index        = (oor || chip_full > WORD_W'(255)) ? 8'hff : chip_full[7:0];
		res_next.block_index       = block_d[L-1];
		res_next.page_index        = page_d[2*L-1][11:0];
		res_next.plane_index       = 12'(chip_full[11:0] * 12'(planes_nz)) + 12'(d_rem[4:0]);
		res_next.channel_index     = c_rem[5:0];
		res_next.chip_out_of_range = oor;
		res_next.scope_first_page  = fp_d[2*L-3];
		res_next.scope_invalid     = inval_d[2*L-3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= c_valid;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_next;
	end

	logic unused_bits;
	assign unused_bits = ^{c_quo, d_quo};

	a_lanes_ab: assert property (@(posedge clk) disable iff (!arst_n) a_valid == p_valid)
		else $error("page and scope dividers out of step");
	a_lanes_cd: assert property (@(posedge clk) disable iff (!arst_n) c_valid == d_valid)
		else $error("channel and plane dividers out of step");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		c_valid |=> result_valid)
		else $error("result strobe lost");
	a_inval: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.scope_invalid) |-> (result.scope_first_page == '1))
		else $error("invalid scope without all-ones first page");
	a_oor: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.chip_out_of_range) |-> (result.chip_index == 8'hff))
		else $error("out of range chip not saturated");

endmodule
